// File: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define PIDW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked while reset is high.
`define PIDW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pidw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_pkg
// Types, constants and Q16.16 arithmetic helpers of the dead band PID block.
// ----------------------------------------------------------------------------
package pidw_pkg;

   // Derivative filter factor, unsigned Q0.16.
   localparam logic [15:0] DERIV_FILTER_Q16 = 16'd0;
   // Decay factor 0.99 as unsigned Q16.16.
   localparam logic [31:0] DECAY_Q16        = 32'd64881;
   localparam logic [31:0] ONE_Q16          = 32'd65536;
   localparam logic [31:0] FILT_NEW_Q16     = ONE_Q16 - {16'd0, DERIV_FILTER_Q16};
   localparam logic [31:0] FILT_OLD_Q16     = {16'd0, DERIV_FILTER_Q16};

   localparam logic [31:0] RST_OUTPUT_LIMIT   = 32'd2147352576;
   localparam logic [31:0] RST_INTEGRAL_BAND  = 32'd2147483647;
   localparam logic [31:0] RST_INTEGRAL_LIMIT = 32'd2147352576;

   typedef enum logic {
      OP_COMPUTE = 1'b0,
      OP_CLEAR   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_OUTPUT_LIMIT   = 3'd3,
      CSR_DEAD_ZONE      = 3'd4,
      CSR_INTEGRAL_BAND  = 3'd5,
      CSR_INTEGRAL_LIMIT = 3'd6,
      CSR_WRAP_RANGE     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] target;
      logic signed [31:0] measured;
   } req_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic signed [31:0] wrapped_error;
      logic               in_dead_band;
   } rsp_type;

   typedef struct packed {
      logic [31:0] gain_p;
      logic [31:0] gain_i;
      logic [31:0] gain_d;
      logic [30:0] output_limit;
      logic [30:0] dead_zone;
      logic [30:0] integral_band;
      logic [30:0] integral_limit;
      logic [30:0] wrap_range;
   } cfg_type;

   // Error stage result.
   typedef struct packed {
      op_type             operation;
      logic signed [31:0] err;
      logic signed [31:0] diff;
      logic               in_dead_band;
      logic               in_int_band;
   } err_type;

   // Gain stage result.
   typedef struct packed {
      op_type             operation;
      logic signed [31:0] err;
      logic               in_dead_band;
      logic               in_int_band;
      logic signed [31:0] prop;
      logic signed [31:0] integ_inc;
      logic signed [31:0] deriv_raw;
   } gain_type;

   function automatic logic signed [35:0] sext36(input logic signed [31:0] v);
      return {{4{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v[35] && !(&v[34:31])) begin
         return 32'sh8000_0000;
      end else if (!v[35] && (|v[34:31])) begin
         return 32'sh7fff_ffff;
      end
      return v[31:0];
   endfunction

   // Q16.16 product, rounded to nearest with ties upward, saturated to 32 bits.
   function automatic logic signed [31:0] mul_q16(input logic signed [31:0] a,
                                                  input logic [31:0]        b);
      logic signed [64:0] prod;
      logic signed [65:0] rnd;
      logic signed [49:0] q;
      prod = a * $signed({1'b0, b});
      rnd  = {prod[64], prod} + 66'sd32768;
      q    = rnd[65:16];
      if (q[49] && !(&q[48:31])) begin
         return 32'sh8000_0000;
      end else if (!q[49] && (|q[48:31])) begin
         return 32'sh7fff_ffff;
      end
      return q[31:0];
   endfunction

   function automatic logic signed [31:0] clamp_sym(input logic signed [35:0] v,
                                                    input logic [30:0]        lim);
      logic signed [35:0] hi;
      logic signed [35:0] lo;
      hi = $signed({5'd0, lim});
      lo = -hi;
      if (v > hi) begin
         return hi[31:0];
      end else if (v < lo) begin
         return lo[31:0];
      end
      return v[31:0];
   endfunction

endpackage

// File: sv/pidw_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_csr
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module pidw_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   output pidw_pkg::cfg_type     cfg
);

   pidw_pkg::cfg_type cfg_ff;
   pidw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pidw_pkg::csr_idx_type'(csr_index))
            pidw_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_data;
            pidw_pkg::CSR_GAIN_I:         cfg_in.gain_i         = csr_data;
            pidw_pkg::CSR_GAIN_D:         cfg_in.gain_d         = csr_data;
            pidw_pkg::CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_data[30:0];
            pidw_pkg::CSR_DEAD_ZONE:      cfg_in.dead_zone      = csr_data[30:0];
            pidw_pkg::CSR_INTEGRAL_BAND:  cfg_in.integral_band  = csr_data[30:0];
            pidw_pkg::CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data[30:0];
            pidw_pkg::CSR_WRAP_RANGE:     cfg_in.wrap_range     = csr_data[30:0];
            default:                      cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.output_limit   <= pidw_pkg::RST_OUTPUT_LIMIT[30:0];
         cfg_ff.dead_zone      <= '0;
         cfg_ff.integral_band  <= pidw_pkg::RST_INTEGRAL_BAND[30:0];
         cfg_ff.integral_limit <= pidw_pkg::RST_INTEGRAL_LIMIT[30:0];
         cfg_ff.wrap_range     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/pidw_err.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_err
// Error stage: saturated error, angle wrap, band tests and error difference.
// ----------------------------------------------------------------------------
module pidw_err (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  pidw_pkg::req_type     req,
   input  pidw_pkg::cfg_type     cfg,
   output pidw_pkg::err_type     err_out
);

   pidw_pkg::err_type  err_ff;
   pidw_pkg::err_type  err_in;
   logic signed [31:0] prev_err_ff;
   logic signed [31:0] prev_err_in;

   logic signed [32:0] raw;
   logic signed [31:0] err_sat;
   logic signed [33:0] e34;
   logic signed [33:0] half34;
   logic signed [33:0] range34;
   logic signed [33:0] wrapped;
   logic signed [31:0] e;
   logic [32:0]        mag;

   always_comb begin
      raw     = $signed({req.target[31], req.target}) -
                $signed({req.measured[31], req.measured});
      err_sat = pidw_pkg::sat32({{3{raw[32]}}, raw});
      e34     = {{2{err_sat[31]}}, err_sat};
      half34  = $signed({4'd0, cfg.wrap_range[30:1]});
      range34 = $signed({3'd0, cfg.wrap_range});
      wrapped = e34;
      // A single correction by the full range, only when wrapping is enabled.
      if (cfg.wrap_range != '0) begin
         if (e34 > half34) begin
            wrapped = e34 - range34;
         end else if (e34 < -half34) begin
            wrapped = e34 + range34;
         end
      end
      e   = pidw_pkg::sat32({{2{wrapped[33]}}, wrapped});
      mag = e[31] ? (33'd0 - {1'b1, e}) : {1'b0, e};

      err_in.operation    = req.operation;
      err_in.err          = e;
      err_in.diff         = pidw_pkg::sat32(pidw_pkg::sext36(e) -
                                            pidw_pkg::sext36(prev_err_ff));
      err_in.in_dead_band = (mag <= {2'd0, cfg.dead_zone});
      err_in.in_int_band  = (mag <= {2'd0, cfg.integral_band});

      prev_err_in = prev_err_ff;
      if (adv && (req.operation == pidw_pkg::OP_COMPUTE)) begin
         prev_err_in = e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
      end else begin
         prev_err_ff <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         err_ff <= err_in;
      end
   end

   assign err_out = err_ff;

endmodule

// File: sv/pidw_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_gain
// Gain stage: the three gain products, each rounded and saturated.
// ----------------------------------------------------------------------------
module pidw_gain (
   input  logic                  clock,
   input  logic                  adv,
   input  pidw_pkg::err_type     err_in,
   input  pidw_pkg::cfg_type     cfg,
   output pidw_pkg::gain_type    gain_out
);

   pidw_pkg::gain_type gain_ff;
   pidw_pkg::gain_type gain_in;

   always_comb begin
      gain_in.operation    = err_in.operation;
      gain_in.err          = err_in.err;
      gain_in.in_dead_band = err_in.in_dead_band;
      gain_in.in_int_band  = err_in.in_int_band;
      gain_in.prop         = pidw_pkg::mul_q16(err_in.err, cfg.gain_p);
      gain_in.integ_inc    = pidw_pkg::mul_q16(err_in.err, cfg.gain_i);
      gain_in.deriv_raw    = pidw_pkg::mul_q16(err_in.diff, cfg.gain_d);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gain_ff <= gain_in;
      end
   end

   assign gain_out = gain_ff;

endmodule

// File: sv/pidw_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_state
// Controller state and result stage: decay, integration, derivative filter,
// output sum and clamps.
// ----------------------------------------------------------------------------
module pidw_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  pidw_pkg::gain_type    gain_in,
   input  pidw_pkg::cfg_type     cfg,
   output pidw_pkg::rsp_type     rsp_out
);

   logic signed [31:0] integ_ff;
   logic signed [31:0] integ_in;
   logic signed [31:0] drive_ff;
   logic signed [31:0] drive_in;
   logic signed [31:0] deriv_ff;
   logic signed [31:0] deriv_in;
   pidw_pkg::rsp_type  rsp_ff;
   pidw_pkg::rsp_type  rsp_in;

   logic signed [31:0] integ_decay;
   logic signed [31:0] drive_decay;
   logic signed [35:0] integ_sum;
   logic signed [31:0] integ_new;
   logic signed [31:0] deriv_new;
   logic signed [35:0] out_sum;
   logic signed [31:0] drive_new;

   always_comb begin
      integ_decay = pidw_pkg::mul_q16(integ_ff, pidw_pkg::DECAY_Q16);
      drive_decay = pidw_pkg::mul_q16(drive_ff, pidw_pkg::DECAY_Q16);

      // Outside the integral band the integral leaks instead of integrating.
      if (gain_in.in_int_band) begin
         integ_sum = pidw_pkg::sext36(integ_ff) + pidw_pkg::sext36(gain_in.integ_inc);
      end else begin
         integ_sum = pidw_pkg::sext36(integ_decay);
      end
      integ_new = pidw_pkg::clamp_sym(integ_sum, cfg.integral_limit);

      deriv_new = pidw_pkg::sat32(
         pidw_pkg::sext36(pidw_pkg::mul_q16(gain_in.deriv_raw, pidw_pkg::FILT_NEW_Q16)) +
         pidw_pkg::sext36(pidw_pkg::mul_q16(deriv_ff, pidw_pkg::FILT_OLD_Q16)));

      out_sum   = pidw_pkg::sext36(gain_in.prop) + pidw_pkg::sext36(integ_new) +
                  pidw_pkg::sext36(deriv_new);
      drive_new = pidw_pkg::clamp_sym(out_sum, cfg.output_limit);

      integ_in = integ_ff;
      drive_in = drive_ff;
      deriv_in = deriv_ff;
      rsp_in   = rsp_ff;
      if (adv) begin
         if (gain_in.operation == pidw_pkg::OP_CLEAR) begin
            integ_in = '0;
            drive_in = '0;
            rsp_in   = '0;
         end else if (gain_in.in_dead_band) begin
            integ_in             = integ_decay;
            drive_in             = drive_decay;
            rsp_in.drive         = drive_decay;
            rsp_in.wrapped_error = gain_in.err;
            rsp_in.in_dead_band  = 1'b1;
         end else begin
            integ_in             = integ_new;
            drive_in             = drive_new;
            deriv_in             = deriv_new;
            rsp_in.drive         = drive_new;
            rsp_in.wrapped_error = gain_in.err;
            rsp_in.in_dead_band  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         drive_ff <= '0;
         deriv_ff <= '0;
      end else begin
         integ_ff <= integ_in;
         drive_ff <= drive_in;
         deriv_ff <= deriv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_out = rsp_ff;

endmodule

// File: sv/pid_controller_deadband_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_deadband_wrap
// Q16.16 PID controller with dead band, integral band, error wrapping and a
// filtered derivative.
// ----------------------------------------------------------------------------
// A beat passes the request, error and gain registers before rsp_valid rises.
// Throughput: one beat per cycle unless the output stalls; the controller state
// loop closes in the output stage, so each beat sees the state left by the one
// before it. Every stage moves on independently, so input beats keep
// flowing into empty stages while a result waits. Reset clears all valid
// flags, the controller state and loads the register defaults.
module pid_controller_deadband_wrap (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pidw_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pidw_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

   pidw_pkg::cfg_type  cfg;
   pidw_pkg::req_type  req_ff;
   pidw_pkg::err_type  err_stage;
   pidw_pkg::gain_type gain_stage;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic s2_valid_ff;
   logic s2_valid_in;
   logic s3_valid_ff;
   logic s3_valid_in;
   logic out_valid_ff;
   logic out_valid_in;

   logic go_out;
   logic rdy3;
   logic rdy2;
   logic rdy1;
   logic adv1;
   logic adv2;
   logic adv3;
   logic req_take;

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      go_out   = !out_valid_ff || rsp_ready;
      rdy3     = !s3_valid_ff || go_out;
      adv3     = s3_valid_ff && go_out;
      rdy2     = !s2_valid_ff || rdy3;
      adv2     = s2_valid_ff && rdy3;
      rdy1     = !s1_valid_ff || rdy2;
      adv1     = s1_valid_ff && rdy2;
      req_take = req_valid && rdy1;

      s1_valid_in  = rdy1   ? req_valid : s1_valid_ff;
      s2_valid_in  = rdy2   ? adv1      : s2_valid_ff;
      s3_valid_in  = rdy3   ? adv2      : s3_valid_ff;
      out_valid_in = go_out ? adv3      : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   pidw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pidw_err u_err (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv1),
      .req     (req_ff),
      .cfg     (cfg),
      .err_out (err_stage)
   );

   pidw_gain u_gain (
      .clock    (clock),
      .adv      (adv2),
      .err_in   (err_stage),
      .cfg      (cfg),
      .gain_out (gain_stage)
   );

   pidw_state u_state (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv3),
      .gain_in (gain_stage),
      .cfg     (cfg),
      .rsp_out (rsp_data)
   );

   assign req_ready = rdy1;
   assign rsp_valid = out_valid_ff;
   assign csr_ready = 1'b1;

endmodule

// File: sv/pidw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidw_checker
// Port level checks of the dead band PID block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidw_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pidw_pkg::rsp_type     rsp_data
);

   // A waiting result beat stays and keeps its payload.
   `PIDW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped while stalled")
   `PIDW_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp_data changed while stalled")

   // With the output register empty, no stage can be blocked.
   `PIDW_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "req_ready low with empty output")

   // No result beat may appear right after reset.
   `PIDW_ASSERT(a_quiet_after_reset, clock, reset, $past(reset) |-> !rsp_valid, "rsp_valid high right after reset")

endmodule

bind pid_controller_deadband_wrap pidw_checker u_pidw_checker (.*);
